### rtl/wam_pkg.sv
package wam_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int COOL_SLOTS = 8;
    localparam int LIST_IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LIST_CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int COOL_IDX_W = (COOL_SLOTS > 1) ? $clog2(COOL_SLOTS) : 1;
    localparam int COOL_CNT_W = $clog2(COOL_SLOTS + 1);
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic signed [7:0] RSSI_ANY = -8'sd99;
    localparam logic [7:0] LED_ON = 8'd255;

    localparam logic [1:0] OP_ADV = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_APPEND = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_OFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_TOTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic                  load;        // capture request
        logic                  list_rd;     // read list entry at scan index
        logic                  list_chk;    // check registered list entry
        logic                  cool_chk;    // check cool slot at scan index
        logic                  do_append;
        logic                  do_clear;
        logic                  do_tick;
        logic                  do_decide;   // cooldown walk finished
        logic                  do_start;    // start alert
        logic                  do_record;   // write cooldown slot
        logic                  out_load;    // load result register
        logic [LIST_IDX_W-1:0] list_idx;
        logic [COOL_IDX_W-1:0] cool_idx;
        logic                  scan_init;
    } wam_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_ok;     // enable and list not empty
        logic       hit;         // list entry matched
        logic       cooling;     // address still cooling down
        logic       idle;        // flash machine idle
        logic [LIST_CNT_W-1:0] used;
    } wam_sts_t;

endpackage

### rtl/wam_ram.sv
module wam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/wam_ctrl.sv
module wam_ctrl
    import wam_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output wam_cmd_t cmd,
    input  wam_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DISPATCH, ST_LREAD, ST_LCHECK, ST_COOL, ST_DECIDE, ST_DONE
    } state_t;

    state_t state_reg;
    logic [LIST_CNT_W-1:0] li_reg;
    logic [COOL_CNT_W-1:0] ci_reg;
    logic m_valid_reg;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd = '0;
        cmd.list_idx = li_reg[LIST_IDX_W-1:0];
        cmd.cool_idx = ci_reg[COOL_IDX_W-1:0];
        cmd.load = s_valid && s_ready;
        case (state_reg)
            ST_DISPATCH: begin
                case (sts.opcode)
                    OP_TICK: cmd.do_tick = 1'b1;
                    OP_APPEND: cmd.do_append = 1'b1;
                    OP_CLEAR: cmd.do_clear = 1'b1;
                    default: cmd.scan_init = 1'b1;
                endcase
            end
            ST_LREAD: cmd.list_rd = 1'b1;
            ST_LCHECK: cmd.list_chk = 1'b1;
            ST_COOL: cmd.cool_chk = 1'b1;
            ST_DECIDE: begin
                cmd.do_decide = 1'b1;
                if (!sts.cooling && sts.idle) begin
                    cmd.do_start = 1'b1;
                    cmd.do_record = 1'b1;
                end
            end
            ST_DONE: cmd.out_load = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            li_reg <= '0;
            ci_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    li_reg <= '0;
                    ci_reg <= '0;
                    if (sts.opcode == OP_ADV && sts.scan_ok) begin
                        state_reg <= ST_LREAD;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LREAD: state_reg <= ST_LCHECK;
                ST_LCHECK: begin
                    if (sts.hit) begin
                        state_reg <= ST_COOL;
                    end else if (li_reg + 1'b1 >= LIST_CNT_W'(sts.used)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        li_reg <= li_reg + 1'b1;
                        state_reg <= ST_LREAD;
                    end
                end
                ST_COOL: begin
                    if (ci_reg == COOL_CNT_W'(COOL_SLOTS - 1)) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        ci_reg <= ci_reg + 1'b1;
                    end
                end
                ST_DECIDE: state_reg <= ST_DONE;
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/wam_datapath.sv
module wam_datapath
    import wam_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wam_cmd_t              cmd,
    output wam_sts_t              sts,
    input  logic [1:0]            s_opcode,
    input  logic [ADDR_W-1:0]     s_device_address,
    input  logic signed [7:0]     s_signal_strength,
    input  logic signed [7:0]     s_entry_threshold,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output logic                  m_matched,
    output logic                  m_alert_started,
    output logic                  m_led_update,
    output logic [7:0]            m_led_red,
    output logic                  m_alert_busy,
    output logic [4:0]            m_list_size
);

    typedef enum logic [1:0] {PH_IDLE, PH_ON, PH_OFF} phase_t;

    logic        enable_reg;
    logic [15:0] on_ticks_reg, off_ticks_reg;
    logic [3:0]  total_reg;
    logic [TIME_W-1:0] cool_ticks_reg;

    logic [1:0]  op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic signed [7:0] rssi_reg, thr_reg;

    logic [LIST_CNT_W-1:0] used_reg;
    logic [TIME_W-1:0] time_reg;
    phase_t phase_reg;
    logic [3:0] done_reg;
    logic [TIME_W:0] deadline_reg;

    logic [ADDR_W-1:0] cool_addr_reg [COOL_SLOTS];
    logic [TIME_W-1:0] cool_time_reg [COOL_SLOTS];
    logic [COOL_SLOTS-1:0] cool_valid_reg;

    logic cooling_reg, found_reg, free_found_reg;
    logic [COOL_IDX_W-1:0] found_idx_reg, free_idx_reg, old_idx_reg;
    logic [TIME_W-1:0] old_time_reg;
    logic matched_reg, started_reg, upd_reg, busy_reg;
    logic [7:0] red_reg;

    logic [ADDR_W-1:0] l_addr;
    logic [7:0] l_thr;
    logic list_we;

    assign list_we = cmd.do_append && (used_reg < LIST_CNT_W'(LIST_DEPTH));

    wam_ram #(.WIDTH(ADDR_W + 8), .DEPTH(LIST_DEPTH)) u_list (
        .aclk  (aclk),
        .we    (list_we),
        .waddr (used_reg[LIST_IDX_W-1:0]),
        .wdata ({addr_reg, thr_reg}),
        .raddr (cmd.list_idx),
        .rdata ({l_addr, l_thr})
    );

    logic entry_hit;
    assign entry_hit = (l_addr == addr_reg) &&
        ((signed'(l_thr) == RSSI_ANY) || !(rssi_reg < signed'(l_thr)));

    logic [TIME_W-1:0] time_inc;
    assign time_inc = (time_reg == TIME_MAX) ? time_reg : time_reg + 1'b1;

    logic [COOL_IDX_W-1:0] rec_idx;
    assign rec_idx = found_reg ? found_idx_reg :
                     (free_found_reg ? free_idx_reg : old_idx_reg);

    assign sts.opcode = op_reg;
    assign sts.scan_ok = enable_reg && (used_reg != '0);
    assign sts.hit = entry_hit;
    assign sts.cooling = cooling_reg;
    assign sts.idle = (phase_reg == PH_IDLE);
    assign sts.used = used_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_opcode;
            addr_reg <= s_device_address;
            rssi_reg <= s_signal_strength;
            thr_reg <= s_entry_threshold;
        end
        if (cmd.out_load) begin
            m_matched <= matched_reg;
            m_alert_started <= started_reg;
            m_led_update <= upd_reg;
            m_led_red <= red_reg;
            m_alert_busy <= busy_reg;
            m_list_size <= 5'(used_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            on_ticks_reg <= 16'd250;
            off_ticks_reg <= 16'd250;
            total_reg <= 4'd3;
            cool_ticks_reg <= 32'd30000;
            used_reg <= '0;
            time_reg <= '0;
            phase_reg <= PH_IDLE;
            done_reg <= '0;
            deadline_reg <= '0;
            cool_valid_reg <= '0;
            for (int i = 0; i < COOL_SLOTS; i++) begin
                cool_addr_reg[i] <= '0;
                cool_time_reg[i] <= '0;
            end
            cooling_reg <= 1'b0;
            found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            found_idx_reg <= '0;
            free_idx_reg <= '0;
            old_idx_reg <= '0;
            old_time_reg <= '0;
            matched_reg <= 1'b0;
            started_reg <= 1'b0;
            upd_reg <= 1'b0;
            busy_reg <= 1'b0;
            red_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ENABLE: begin
                        enable_reg <= cfg_data[0];
                        phase_reg <= PH_IDLE;
                    end
                    REG_FLASH_ON: on_ticks_reg <= cfg_data[15:0];
                    REG_FLASH_OFF: off_ticks_reg <= cfg_data[15:0];
                    REG_FLASH_TOTAL: total_reg <= cfg_data[3:0];
                    REG_COOLDOWN: cool_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.scan_init || cmd.do_tick || cmd.do_append || cmd.do_clear) begin
                matched_reg <= 1'b0;
                started_reg <= 1'b0;
                upd_reg <= 1'b0;
                busy_reg <= 1'b0;
                red_reg <= '0;
                found_reg <= 1'b0;
                free_found_reg <= 1'b0;
                cooling_reg <= 1'b0;
                old_idx_reg <= '0;
                old_time_reg <= cool_time_reg[0];
            end
            if (list_we) begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.do_clear) begin
                used_reg <= '0;
            end
            if (cmd.do_tick) begin
                time_reg <= time_inc;
                if (phase_reg != PH_IDLE) begin
                    upd_reg <= 1'b1;
                    busy_reg <= 1'b1;
                    if ({1'b0, time_inc} < deadline_reg) begin
                        red_reg <= (phase_reg == PH_ON) ? LED_ON : 8'd0;
                    end else if (phase_reg == PH_ON) begin
                        done_reg <= done_reg + 1'b1;
                        if (done_reg + 1'b1 >= total_reg) begin
                            phase_reg <= PH_IDLE;
                            busy_reg <= 1'b0;
                        end else begin
                            phase_reg <= PH_OFF;
                            deadline_reg <= {1'b0, time_inc} + (TIME_W+1)'(off_ticks_reg);
                        end
                    end else begin
                        phase_reg <= PH_ON;
                        deadline_reg <= {1'b0, time_inc} + (TIME_W+1)'(on_ticks_reg);
                        red_reg <= LED_ON;
                    end
                end
            end
            // one cooldown slot a cycle: exact hit, first free, first oldest
            if (cmd.cool_chk) begin
                if (cool_valid_reg[cmd.cool_idx] &&
                    cool_addr_reg[cmd.cool_idx] == addr_reg && !found_reg) begin
                    found_reg <= 1'b1;
                    found_idx_reg <= cmd.cool_idx;
                    cooling_reg <= (time_reg - cool_time_reg[cmd.cool_idx]) < cool_ticks_reg;
                end
                if (!cool_valid_reg[cmd.cool_idx] && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg <= cmd.cool_idx;
                end
                if (cool_time_reg[cmd.cool_idx] < old_time_reg) begin
                    old_time_reg <= cool_time_reg[cmd.cool_idx];
                    old_idx_reg <= cmd.cool_idx;
                end
            end
            if (cmd.do_start) begin
                done_reg <= '0;
                phase_reg <= PH_ON;
                deadline_reg <= {1'b0, time_reg} + (TIME_W+1)'(on_ticks_reg);
                started_reg <= 1'b1;
            end
            if (cmd.do_record) begin
                cool_addr_reg[rec_idx] <= addr_reg;
                cool_time_reg[rec_idx] <= time_reg;
                cool_valid_reg[rec_idx] <= 1'b1;
            end
            // not cooling down: matched, whether or not an alert starts
            if (cmd.do_decide && !cooling_reg) begin
                matched_reg <= 1'b1;
            end
        end
    end

endmodule

### rtl/watchlist_alert_matcher_unit.sv
// watchlist alert matcher
// input channel s_valid/s_ready carries one request: opcode, device_address,
// signal_strength and entry_threshold. every request gives exactly one result
// on m_valid/m_ready. a tick advances time and runs the led flash machine;
// an append writes the next watchlist entry; a clear empties the list; an
// advertisement scans the list one entry at a time (ram read, then
// compare) and, on a hit, walks the eight cooldown slots one per cycle.
// one request is in flight at a time; the next one can be taken at the
// edge its predecessor's result is taken.
// the result stays in its output register until taken; s_ready stays low
// while a result waits, so a stalled receiver holds the input.
// reset (aresetn low, synchronous) empties the list, clears the cooldown
// table, time and flash machine, and restores register defaults.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module watchlist_alert_matcher_unit
    import wam_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [ADDR_W-1:0]    s_device_address,
    input  logic signed [7:0]    s_signal_strength,
    input  logic signed [7:0]    s_entry_threshold,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_matched,
    output logic                 m_alert_started,
    output logic                 m_led_update,
    output logic [7:0]           m_led_red,
    output logic                 m_alert_busy,
    output logic [4:0]           m_list_size,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    wam_cmd_t cmd;
    wam_sts_t sts;

    wam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    wam_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_opcode          (s_opcode),
        .s_device_address  (s_device_address),
        .s_signal_strength (s_signal_strength),
        .s_entry_threshold (s_entry_threshold),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_matched         (m_matched),
        .m_alert_started   (m_alert_started),
        .m_led_update      (m_led_update),
        .m_led_red         (m_led_red),
        .m_alert_busy      (m_alert_busy),
        .m_list_size       (m_list_size)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wam_pkg::*;

    localparam int MAX_IDLE_CYCLES = 20000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic       matched;
        logic       alert_started;
        logic       led_update;
        logic [7:0] led_red;
        logic       alert_busy;
        logic [4:0] list_size;
    } alert_result_t;

    typedef struct {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] addr;
        logic signed [7:0] rssi;
        logic signed [7:0] thr;
        bit                typed;
        alert_result_t     want;
    } stim_row_t;

    typedef enum logic [1:0] {PH_IDLE, PH_ON, PH_OFF} flash_phase_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_opcode = OP_TICK;
    logic [ADDR_W-1:0]    s_device_address = '0;
    logic signed [7:0]    s_signal_strength = '0;
    logic signed [7:0]    s_entry_threshold = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_matched;
    logic                 m_alert_started;
    logic                 m_led_update;
    logic [7:0]           m_led_red;
    logic                 m_alert_busy;
    logic [4:0]           m_list_size;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    always #6 aclk = ~aclk;

    watchlist_alert_matcher_unit u_dut (.*);

    // predictor state
    logic [15:0]        flash_on_len, flash_off_len;
    logic [3:0]         flash_limit;
    logic [31:0]        cool_len;
    logic               lookout_on;
    logic [ADDR_W-1:0]  wl_addr [LIST_DEPTH];
    logic signed [7:0]  wl_thr [LIST_DEPTH];
    int                 wl_used;
    logic [ADDR_W-1:0]  cd_addr [COOL_SLOTS];
    logic [31:0]        cd_time [COOL_SLOTS];
    bit                 cd_valid [COOL_SLOTS];
    logic [31:0]        now_ticks;
    flash_phase_t       phase;
    logic [3:0]         flashes;
    logic [32:0]        deadline;

    alert_result_t pending_results[$];
    int  mismatches = 0;
    int  results_seen = 0, alerts_seen = 0, matches_seen = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0, recv_stall_pct = 0;
    bit  hold_off = 1'b0;
    logic [ADDR_W-1:0] addr_pool [6];

    function automatic bit addr_cooling(logic [ADDR_W-1:0] a);
        for (int i = 0; i < COOL_SLOTS; i++)
            if (cd_valid[i] && cd_addr[i] == a) return (now_ticks - cd_time[i]) < cool_len;
        return 1'b0;
    endfunction

    function automatic void note_cooldown(logic [ADDR_W-1:0] a);
        int pick;
        pick = -1;
        for (int i = 0; i < COOL_SLOTS; i++)
            if (cd_valid[i] && cd_addr[i] == a) begin
                cd_time[i] = now_ticks;
                return;
            end
        for (int i = 0; i < COOL_SLOTS; i++)
            if (pick < 0 && !cd_valid[i]) pick = i;
        if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < COOL_SLOTS; i++)
                if (cd_time[i] < cd_time[pick]) pick = i;
        end
        cd_addr[pick] = a;
        cd_time[pick] = now_ticks;
        cd_valid[pick] = 1'b1;
    endfunction

    function automatic alert_result_t predict_alert(logic [1:0] op, logic [ADDR_W-1:0] a,
                                                    logic signed [7:0] rssi,
                                                    logic signed [7:0] thr);
        alert_result_t r;
        r = '0;
        case (op)
            OP_ADV: begin
                if (lookout_on && wl_used != 0) begin
                    for (int i = 0; i < wl_used; i++) begin
                        if (wl_addr[i] != a) continue;
                        if (wl_thr[i] != RSSI_ANY && rssi < wl_thr[i]) continue;
                        if (!addr_cooling(a)) begin
                            r.matched = 1'b1;
                            if (phase == PH_IDLE) begin
                                note_cooldown(a);
                                flashes = '0;
                                phase = PH_ON;
                                deadline = {1'b0, now_ticks} + flash_on_len;
                                r.alert_started = 1'b1;
                            end
                        end
                        break;
                    end
                end
            end
            OP_TICK: begin
                if (now_ticks != TIME_MAX) now_ticks++;
                if (phase != PH_IDLE) begin
                    r.led_update = 1'b1;
                    r.alert_busy = 1'b1;
                    if ({1'b0, now_ticks} < deadline) begin
                        r.led_red = (phase == PH_ON) ? LED_ON : 8'd0;
                    end else if (phase == PH_ON) begin
                        flashes++;
                        if (flashes >= flash_limit) begin
                            phase = PH_IDLE;
                            r.alert_busy = 1'b0;
                        end else begin
                            phase = PH_OFF;
                            deadline = {1'b0, now_ticks} + flash_off_len;
                        end
                    end else begin
                        phase = PH_ON;
                        deadline = {1'b0, now_ticks} + flash_on_len;
                        r.led_red = LED_ON;
                    end
                end
            end
            OP_APPEND: begin
                if (wl_used < LIST_DEPTH) begin
                    wl_addr[wl_used] = a;
                    wl_thr[wl_used] = thr;
                    wl_used++;
                end
            end
            default: wl_used = 0;
        endcase
        r.list_size = wl_used[4:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE: begin
                lookout_on = val[0];
                phase = PH_IDLE;
            end
            REG_FLASH_ON: flash_on_len = val[15:0];
            REG_FLASH_OFF: flash_off_len = val[15:0];
            REG_FLASH_TOTAL: flash_limit = val[3:0];
            default: cool_len = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // drive at falling edge; hold valid until accepted
    task automatic send_request(logic [1:0] op, logic [ADDR_W-1:0] a,
                                logic signed [7:0] rssi, logic signed [7:0] thr,
                                bit typed, alert_result_t want);
        alert_result_t got;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_device_address <= a;
        s_signal_strength <= rssi;
        s_entry_threshold <= thr;
        do @(posedge aclk); while (!s_ready);
        got = predict_alert(op, a, rssi, thr);
        if (typed && got != want && mismatches++ < 10)
            $display("typed row disagrees: op %0d want %h model %h", op, want, got);
        pending_results.push_back(got);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic send_random(int n);
        logic [1:0] op;
        logic [ADDR_W-1:0] a;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 40) op = OP_TICK;
            else if (k < 75) op = OP_ADV;
            else if (k < 96) op = OP_APPEND;
            else op = OP_CLEAR;
            a = ($urandom_range(9) == 0) ? ADDR_W'({$urandom, $urandom})
                                         : addr_pool[$urandom_range(5)];
            send_request(op, a, 8'($urandom), ($urandom_range(3) == 0) ? RSSI_ANY : 8'($urandom),
                         1'b0, '0);
        end
    endtask

    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        alert_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_matched, m_alert_started, m_led_update, m_led_red,
                    m_alert_busy, m_list_size};
            results_seen++;
            if (pending_results.size() == 0) begin
                if (mismatches++ < 10) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                alerts_seen += got.alert_started;
                matches_seen += got.matched;
                if (got != want && mismatches++ < 10)
                    $display("mismatch: expected %h actual %h", want, got);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || hold_off ||
            (!s_valid && pending_results.size() == 0))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= MAX_IDLE_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        stim_row_t rows[$];
        int phase_pct [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{20, 20}};

        for (int i = 0; i < 6; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        lookout_on = 0; flash_on_len = 250; flash_off_len = 250; flash_limit = 3;
        cool_len = 30000; wl_used = 0; now_ticks = 0; phase = PH_IDLE;
        flashes = 0; deadline = 0;
        for (int i = 0; i < COOL_SLOTS; i++) begin
            cd_valid[i] = 0; cd_addr[i] = '0; cd_time[i] = '0;
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // after reset: disabled lookout, nothing matches
        rows.push_back('{OP_TICK, '0, 0, 0, 1, alert_result_t'('0)});
        rows.push_back('{OP_APPEND, '1, 0, RSSI_ANY, 1, alert_result_t'(5'd1)});
        rows.push_back('{OP_ADV, '1, -128, 0, 1, alert_result_t'(5'd1)});
        rows.push_back('{OP_CLEAR, '0, 0, 0, 1, alert_result_t'('0)});
        foreach (rows[i])
            send_request(rows[i].opcode, rows[i].addr, rows[i].rssi, rows[i].thr,
                         rows[i].typed, rows[i].want);
        wait_drained();

        write_reg(REG_ENABLE, 1);
        write_reg(REG_FLASH_ON, 2);
        write_reg(REG_FLASH_OFF, 1);
        write_reg(REG_FLASH_TOTAL, 2);
        write_reg(REG_COOLDOWN, 5);
        rows.delete();
        // thresholds: any, max, min; empty list match; duplicate address
        rows.push_back('{OP_ADV, '1, 127, 0, 1, alert_result_t'('0)});
        rows.push_back('{OP_APPEND, '1, 0, RSSI_ANY, 0, '0});
        rows.push_back('{OP_APPEND, '0, 0, 127, 0, '0});
        rows.push_back('{OP_APPEND, 48'h5555_AAAA_5555, 0, -128, 0, '0});
        rows.push_back('{OP_ADV, '1, -128, 0, 0, '0});
        rows.push_back('{OP_ADV, '0, 126, 0, 0, '0});
        for (int i = 0; i < 8; i++) rows.push_back('{OP_TICK, '0, 0, 0, 0, '0});
        rows.push_back('{OP_ADV, '0, 127, 0, 0, '0});
        rows.push_back('{OP_ADV, '1, 0, 0, 0, '0});
        rows.push_back('{OP_ADV, 48'h5555_AAAA_5555, -128, 0, 0, '0});
        foreach (rows[i])
            send_request(rows[i].opcode, rows[i].addr, rows[i].rssi, rows[i].thr,
                         rows[i].typed, rows[i].want);
        // fill the list past full
        for (int i = 0; i < 15; i++)
            send_request(OP_APPEND, addr_pool[i % 6], 0, 8'($urandom), 0, '0);
        wait_drained();

        // back-pressure: receiver holds off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            send_random(20);
        join
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            send_random(190);
            wait_drained();
            case (p)
                0: begin
                    write_reg(REG_FLASH_ON, 65535);
                    write_reg(REG_FLASH_TOTAL, 15);
                    write_reg(REG_COOLDOWN, 0);
                    write_reg(REG_ENABLE, 1);
                end
                1: begin
                    write_reg(REG_FLASH_ON, 1);
                    write_reg(REG_FLASH_OFF, 65535);
                    write_reg(REG_FLASH_TOTAL, 1);
                    write_reg(REG_COOLDOWN, 32'hFFFF_FFFF);
                    write_reg(REG_ENABLE, 1);
                end
                2: begin
                    write_reg(REG_FLASH_OFF, 2);
                    write_reg(REG_FLASH_TOTAL, 0);
                    write_reg(REG_COOLDOWN, 3);
                    write_reg(REG_ENABLE, 0);
                    write_reg(REG_ENABLE, 1);
                end
                default: ;
            endcase
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        $display("covered %0d results: %0d matches, %0d alerts started, over several",
                 results_seen, matches_seen, alerts_seen);
        $display("flash and cooldown settings with idle, stall and hold-off phases");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### files.f
rtl/wam_pkg.sv
rtl/wam_ram.sv
rtl/wam_ctrl.sv
rtl/wam_datapath.sv
rtl/watchlist_alert_matcher_unit.sv
sim/tb_top.sv
